>>> rtl/tvlf_pkg.sv
// ---------------------------------------------------------------------------
// tvlf_pkg: shared types and constants of the text view line formatter
// Item, result, configuration and queue entry types, slot layout of one
// queue entry and the character codes that the formatter emits.
// ---------------------------------------------------------------------------
package tvlf_pkg;

    // number of decimal digits in the line number prefix
    localparam int NUM_DIGITS = 6;
    localparam int BCD_W      = NUM_DIGITS * 4;

    // output slot layout: digits first, then tab, dollar, M, dash, caret, byte
    localparam int SLOT_TAB       = NUM_DIGITS;
    localparam int SLOT_DOLLAR    = NUM_DIGITS + 1;
    localparam int SLOT_META_M    = NUM_DIGITS + 2;
    localparam int SLOT_META_DASH = NUM_DIGITS + 3;
    localparam int SLOT_CARET     = NUM_DIGITS + 4;
    localparam int SLOT_FINAL     = NUM_DIGITS + 5;
    localparam int SLOT_COUNT     = NUM_DIGITS + 6;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

    // character codes
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_DOLLAR  = 8'd36;
    localparam logic [7:0] CH_DASH    = 8'd45;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_QMARK   = 8'd63;
    localparam logic [7:0] CH_UPPER_I = 8'd73;
    localparam logic [7:0] CH_UPPER_M = 8'd77;
    localparam logic [7:0] CH_CARET   = 8'd94;
    localparam logic [7:0] CH_DEL     = 8'd127;
    localparam logic [7:0] CTRL_SHIFT = 8'd64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic number_all;
        logic number_nonblank;
        logic show_ends;
        logic squeeze_blank;
        logic show_tabs;
        logic show_nonprinting;
    } t_cfg;

    // one classified item: which slots to emit, the number and the final byte
    typedef struct packed {
        logic [SLOT_COUNT-1:0]            slot_mask;
        logic                             numbered;
        logic [NUM_DIGITS-1:0][3:0]       bcd;
        logic [7:0]                       final_byte;
    } t_entry;

endpackage

>>> rtl/tvlf_front.sv
// ---------------------------------------------------------------------------
// tvlf_front: item classification and line state
// Keeps the line state and the decimal line count, decides the prefix,
// dollar and escape bytes of accepted items and queues all but squeezed ones.
// ---------------------------------------------------------------------------
module tvlf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tvlf_pkg::t_cfg    i_cfg,
    input  logic              i_push,
    input  tvlf_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_q_push,
    output tvlf_pkg::t_entry  o_entry
);

    logic                                   r_prev_nl;
    logic                                   r_blank_seen;
    logic [tvlf_pkg::NUM_DIGITS-1:0][3:0]   r_count;
    logic                                   n_prev_nl;
    logic                                   n_blank_seen;
    logic [tvlf_pkg::NUM_DIGITS-1:0][3:0]   n_count;

    logic                                   accept;
    logic                                   is_nl;
    logic                                   eff_prev;
    logic                                   eff_blank;
    logic [tvlf_pkg::NUM_DIGITS-1:0][3:0]   eff_count;
    logic [tvlf_pkg::NUM_DIGITS-1:0][3:0]   inc_count;
    logic                                   all_nine;
    logic                                   carry;
    logic                                   drop;
    logic                                   numbered;
    logic                                   spaced;
    logic                                   meta;
    logic                                   caret;
    logic [7:0]                             c;
    logic [7:0]                             v;

    assign accept = i_push && !i_full;
    assign c      = i_item.data_byte;
    assign is_nl  = (c == tvlf_pkg::CH_NL);

    // file start clears the line state ahead of this byte
    assign eff_prev  = i_item.file_start ? 1'b1 : r_prev_nl;
    assign eff_blank = i_item.file_start ? 1'b0 : r_blank_seen;
    assign eff_count = i_item.file_start ? '0 : r_count;

    // second blank line in a row with squeezing on gives no output
    assign drop = i_cfg.squeeze_blank && eff_prev && is_nl && eff_blank;

    assign numbered = eff_prev && ((i_cfg.number_all && !i_cfg.number_nonblank) ||
                                   (i_cfg.number_nonblank && !is_nl));
    assign spaced   = !numbered && eff_prev && i_cfg.number_nonblank && i_cfg.show_ends;

    // saturating decimal increment, one digit at a time
    always_comb begin
        all_nine  = 1'b1;
        carry     = 1'b1;
        inc_count = eff_count;
        for (int k = 0; k < tvlf_pkg::NUM_DIGITS; k++) begin
            if (eff_count[k] != 4'd9) begin
                all_nine = 1'b0;
            end
            if (carry) begin
                if (eff_count[k] == 4'd9) begin
                    inc_count[k] = 4'd0;
                end else begin
                    inc_count[k] = eff_count[k] + 4'd1;
                    carry        = 1'b0;
                end
            end
        end
        if (all_nine) begin
            inc_count = eff_count;
        end
    end

    // escape classification of the byte itself
    always_comb begin
        meta  = 1'b0;
        caret = 1'b0;
        v     = c;
        if (i_cfg.show_tabs && c == tvlf_pkg::CH_TAB) begin
            caret = 1'b1;
            v     = tvlf_pkg::CH_UPPER_I;
        end else if (i_cfg.show_nonprinting) begin
            if (c inside {[8'd128:8'd159]}) begin
                meta  = 1'b1;
                caret = 1'b1;
                v     = c - tvlf_pkg::CTRL_SHIFT;
            end else if (c == tvlf_pkg::CH_DEL) begin
                caret = 1'b1;
                v     = tvlf_pkg::CH_QMARK;
            end else if (c < 8'd32 && c != tvlf_pkg::CH_NL && c != tvlf_pkg::CH_TAB) begin
                caret = 1'b1;
                v     = c + tvlf_pkg::CTRL_SHIFT;
            end
        end
    end

    // queue entry
    always_comb begin
        o_entry = '0;
        for (int s = 0; s <= tvlf_pkg::SLOT_TAB; s++) begin
            o_entry.slot_mask[s] = numbered || spaced;
        end
        o_entry.slot_mask[tvlf_pkg::SLOT_DOLLAR]    = i_cfg.show_ends && is_nl;
        o_entry.slot_mask[tvlf_pkg::SLOT_META_M]    = meta;
        o_entry.slot_mask[tvlf_pkg::SLOT_META_DASH] = meta;
        o_entry.slot_mask[tvlf_pkg::SLOT_CARET]     = caret;
        o_entry.slot_mask[tvlf_pkg::SLOT_FINAL]     = 1'b1;
        o_entry.numbered   = numbered;
        o_entry.bcd        = inc_count;
        o_entry.final_byte = v;
    end

    assign o_q_push = accept && !drop;

    // next line state
    always_comb begin
        n_prev_nl    = r_prev_nl;
        n_blank_seen = r_blank_seen;
        n_count      = r_count;
        if (accept) begin
            n_prev_nl    = eff_prev;
            n_blank_seen = eff_blank;
            n_count      = eff_count;
            if (!drop) begin
                n_prev_nl    = is_nl;
                n_blank_seen = eff_prev && is_nl;
                if (numbered) begin
                    n_count = inc_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_nl    <= 1'b1;
            r_blank_seen <= 1'b0;
            r_count      <= '0;
        end else begin
            r_prev_nl    <= n_prev_nl;
            r_blank_seen <= n_blank_seen;
            r_count      <= n_count;
        end
    end

endmodule

>>> rtl/tvlf_queue.sv
// ---------------------------------------------------------------------------
// tvlf_queue: short entry queue between front and back
// Flip-flop queue of classified items so that the front and the back can
// stall independently.
// ---------------------------------------------------------------------------
module tvlf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tvlf_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output tvlf_pkg::t_entry o_head
);

    tvlf_pkg::t_entry                r_mem [tvlf_pkg::QUEUE_DEPTH];
    logic [tvlf_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [tvlf_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [tvlf_pkg::QCNT_W-1:0]     r_count;

    assign o_full  = (r_count == tvlf_pkg::QCNT_W'(tvlf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/tvlf_back.sv
// ---------------------------------------------------------------------------
// tvlf_back: byte sequencer
// Walks the enabled slots of the head entry into the output register, one
// byte per cycle while it can load, releasing the entry with its final byte.
// ---------------------------------------------------------------------------
module tvlf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tvlf_pkg::t_entry      i_head,
    input  logic                  i_q_empty,
    output logic                  o_q_pop,
    input  logic                  i_out_pop,
    output logic                  o_out_valid,
    output tvlf_pkg::t_out_item   o_out_item
);

    logic [tvlf_pkg::SLOT_COUNT-1:0] r_done;
    logic                            r_out_valid;
    tvlf_pkg::t_out_item             r_out;

    logic [tvlf_pkg::SLOT_COUNT-1:0] remaining;
    logic [tvlf_pkg::SLOT_COUNT-1:0] pick;
    logic [tvlf_pkg::SLOT_COUNT-1:0] rest;
    logic [7:0]                      slot_byte [tvlf_pkg::SLOT_COUNT];
    logic [7:0]                      sel_byte;
    logic                            leading_zero;
    logic                            can_load;

    // lowest slot still to go
    assign remaining = i_head.slot_mask & ~r_done;
    assign pick      = remaining & (~remaining + 1'b1);
    assign rest      = remaining & ~pick;
    assign can_load  = !i_q_empty && (!r_out_valid || i_out_pop);
    assign o_q_pop   = can_load && (rest == '0);

    // byte of each slot, leading zeros but the last and unnumbered digits blank
    always_comb begin
        leading_zero = 1'b1;
        for (int s = 0; s < tvlf_pkg::NUM_DIGITS; s++) begin
            if (i_head.bcd[tvlf_pkg::NUM_DIGITS-1-s] != 4'd0) begin
                leading_zero = 1'b0;
            end
            if (!i_head.numbered || (leading_zero && s != tvlf_pkg::NUM_DIGITS - 1)) begin
                slot_byte[s] = tvlf_pkg::CH_SPACE;
            end else begin
                slot_byte[s] = tvlf_pkg::CH_ZERO + {4'd0, i_head.bcd[tvlf_pkg::NUM_DIGITS-1-s]};
            end
        end
        slot_byte[tvlf_pkg::SLOT_TAB]       = tvlf_pkg::CH_TAB;
        slot_byte[tvlf_pkg::SLOT_DOLLAR]    = tvlf_pkg::CH_DOLLAR;
        slot_byte[tvlf_pkg::SLOT_META_M]    = tvlf_pkg::CH_UPPER_M;
        slot_byte[tvlf_pkg::SLOT_META_DASH] = tvlf_pkg::CH_DASH;
        slot_byte[tvlf_pkg::SLOT_CARET]     = tvlf_pkg::CH_CARET;
        slot_byte[tvlf_pkg::SLOT_FINAL]     = i_head.final_byte;
    end

    // one-hot select of the picked slot
    always_comb begin
        sel_byte = '0;
        for (int s = 0; s < tvlf_pkg::SLOT_COUNT; s++) begin
            if (pick[s]) begin
                sel_byte = sel_byte | slot_byte[s];
            end
        end
    end

    // slot progress within the head entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (can_load) begin
            r_done <= (rest == '0) ? '0 : (r_done | pick);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load) begin
            r_out.out_byte <= sel_byte;
            r_out.last     <= (rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> rtl/text_view_line_formatter.sv
// ---------------------------------------------------------------------------
// text_view_line_formatter: cat-style text output formatter
// Line numbering, end marks, blank line squeezing and caret notation for a
// byte stream, one text byte in and one formatted byte out per transfer.
// ---------------------------------------------------------------------------
// Each accepted text byte yields from one to eleven output bytes (none for a
// squeezed blank line); the last output byte of a text byte carries last.
// The output side delivers one byte per cycle while the consumer pops; plain
// bytes then stream at one per cycle. Input is taken every cycle while the
// four-entry queue between the classifier and the byte sequencer has room,
// so full rises only when the output side falls behind. An input byte is
// written into the queue, then loaded into the output register. Configuration
// is written through the cfg channel, which is always ready; the user must
// write it only while the block is idle, which the block does not enforce.
module text_view_line_formatter (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  tvlf_pkg::t_in_item       i_in_item,
    output logic                     empty,
    input  logic                     pop,
    output tvlf_pkg::t_out_item      o_out_item,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [tvlf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                     i_cfg_data
);

    tvlf_pkg::t_cfg   r_cfg;
    tvlf_pkg::t_entry fq_entry;
    tvlf_pkg::t_entry q_head;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic             out_valid;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tvlf_pkg::REG_NUMBER_ALL:       r_cfg.number_all       <= i_cfg_data;
                tvlf_pkg::REG_NUMBER_NONBLANK:  r_cfg.number_nonblank  <= i_cfg_data;
                tvlf_pkg::REG_SHOW_ENDS:        r_cfg.show_ends        <= i_cfg_data;
                tvlf_pkg::REG_SQUEEZE_BLANK:    r_cfg.squeeze_blank    <= i_cfg_data;
                tvlf_pkg::REG_SHOW_TABS:        r_cfg.show_tabs        <= i_cfg_data;
                tvlf_pkg::REG_SHOW_NONPRINTING: r_cfg.show_nonprinting <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classifier
    tvlf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_item   (i_in_item),
        .i_full   (q_full),
        .o_q_push (q_push),
        .o_entry  (fq_entry)
    );

    // entry queue
    tvlf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (fq_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // byte sequencer
    tvlf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_out_pop   (pop),
        .o_out_valid (out_valid),
        .o_out_item  (o_out_item)
    );

    assign full  = q_full;
    assign empty = !out_valid;

    // front never writes a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("entry written into a full queue");

    // back never releases an entry that is not there
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("entry released from an empty queue");

    // releasing an entry leaves its final byte in the output register
    a_release_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (!empty && o_out_item.last))
        else $error("entry released without its final byte");

endmodule
